// ----- sv/ntc_pkg.sv -----
// ----------------------------------------------------------------------
// NTC converter package
// Shared widths, constants, codes and structures of the converter.
// ----------------------------------------------------------------------
package ntc_pkg;

   localparam int DEF_OVERSAMPLE = 32;
   localparam int DEF_CHANNELS   = 2;
   localparam int QUEUE_DEPTH    = 2;

   localparam int SAMPLE_W = 10;
   localparam int SUM_W    = 15;
   localparam int CNT_W    = 6;
   localparam int RES_W    = 32;
   localparam int TEMP_W   = 21;
   localparam int STAT_W   = 2;
   localparam int IDX_W    = 3;
   localparam int DATA_W   = 24;
   localparam int PULLUP_W = 16;
   localparam int NOM_W    = 24;
   localparam int BETA_W   = 16;
   localparam int DIV_W    = 64;

   // Register indexes.
   localparam logic [IDX_W-1:0] REG_PULLUP_CH0  = 3'd0;
   localparam logic [IDX_W-1:0] REG_PULLUP_CH1  = 3'd1;
   localparam logic [IDX_W-1:0] REG_NOMINAL_CH0 = 3'd2;
   localparam logic [IDX_W-1:0] REG_NOMINAL_CH1 = 3'd3;
   localparam logic [IDX_W-1:0] REG_BETA_CH0    = 3'd4;
   localparam logic [IDX_W-1:0] REG_BETA_CH1    = 3'd5;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_NORMAL = 2'd0;
   localparam logic [STAT_W-1:0] ST_SHORT  = 2'd1;
   localparam logic [STAT_W-1:0] ST_OPEN   = 2'd2;
   localparam logic [STAT_W-1:0] ST_SAT    = 2'd3;

   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam logic [DIV_W-1:0] INV0 = (64'd20 << 48) / 64'd5963;
   localparam logic [DIV_W-1:0] Q_NUM = 64'd16000 << 48;
   localparam logic signed [TEMP_W-1:0] LIMIT_MC = 21'sd999000;
   localparam logic signed [41:0] ZERO_C_16 = 42'sd4370400;

   typedef struct packed {
      logic             channel;
      logic [SUM_W-1:0] sum;
   } ntc_entry_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- sv/ntc_if.sv -----
// ----------------------------------------------------------------------
// NTC converter channels
// Sample, result and register write channels with valid/ready.
// ----------------------------------------------------------------------
interface ntc_req_if;
   import ntc_pkg::*;
   logic                valid;
   logic                ready;
   logic                channel;
   logic [SAMPLE_W-1:0] sample;
   modport source (output valid, channel, sample, input ready);
   modport sink (input valid, channel, sample, output ready);
endinterface

interface ntc_rsp_if;
   import ntc_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     out_channel;
   logic [SUM_W-1:0]         raw_sum;
   logic [RES_W-1:0]         resistance_ohms;
   logic signed [TEMP_W-1:0] temp_mdeg;
   logic [STAT_W-1:0]        status;
   modport source (output valid, out_channel, raw_sum, resistance_ohms, temp_mdeg, status,
                   input ready);
   modport sink (input valid, out_channel, raw_sum, resistance_ohms, temp_mdeg, status,
                 output ready);
endinterface

interface ntc_csr_if;
   import ntc_pkg::*;
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  index;
   logic [DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/ntc_thermistor_converter.sv -----
// ----------------------------------------------------------------------
// NTC thermistor converter
// Oversampled divider readings to resistance and Beta-equation temperature.
// ----------------------------------------------------------------------
// Samples are taken one per clock cycle whenever the two-entry reading queue
// has room; each reading spans OVERSAMPLE_COUNT + 1 samples of a channel, the
// first of which is dropped. A completed reading that runs the full equation
// is converted by the back end with three passes of the shared 64-step divider
// (resistance, ln/Beta, reciprocal temperature) and two logarithms of up to 31
// normalizing shifts and 32 squaring steps each. A reading with a zero or
// full-scale sum skips the divider and the logarithms. Results
// leave through a registered output, so a new conversion can finish while
// the previous result is still waiting. Register writes are always accepted.
// ----------------------------------------------------------------------
module ntc_thermistor_converter #(
   parameter int OVERSAMPLE_COUNT = ntc_pkg::DEF_OVERSAMPLE,
   parameter int CHANNELS         = ntc_pkg::DEF_CHANNELS
) (
   input  logic      clock,
   input  logic      reset,
   ntc_req_if.sink   req_if,
   ntc_rsp_if.source rsp_if,
   ntc_csr_if.sink   csr_if
);
   import ntc_pkg::*;

   logic          push, full, pop, empty;
   ntc_entry_type push_entry, head;
   div_req_type   div_req;
   div_rsp_type   div_rsp;

   ntc_front #(
      .OVERSAMPLE_COUNT(OVERSAMPLE_COUNT),
      .CHANNELS(CHANNELS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .full(full),
      .push(push),
      .push_entry(push_entry)
   );

   ntc_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_entry(push_entry),
      .full(full),
      .pop(pop),
      .empty(empty),
      .head(head)
   );

   ntc_div u_div (
      .clock(clock),
      .reset(reset),
      .req(div_req),
      .rsp(div_rsp)
   );

   ntc_back #(
      .OVERSAMPLE_COUNT(OVERSAMPLE_COUNT)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .csr_if(csr_if),
      .rsp_if(rsp_if),
      .empty(empty),
      .head(head),
      .pop(pop),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

endmodule

// ----- sv/ntc_front.sv -----
// ----------------------------------------------------------------------
// NTC front end
// Per-channel sample accumulation; completed readings go to the queue.
// ----------------------------------------------------------------------
module ntc_front #(
   parameter int OVERSAMPLE_COUNT = ntc_pkg::DEF_OVERSAMPLE,
   parameter int CHANNELS         = ntc_pkg::DEF_CHANNELS
) (
   input  logic                   clock,
   input  logic                   reset,
   ntc_req_if.sink                req_if,
   input  logic                   full,
   output logic                   push,
   output ntc_pkg::ntc_entry_type push_entry
);
   import ntc_pkg::*;

   localparam logic [CNT_W-1:0] LastCount = CNT_W'(OVERSAMPLE_COUNT + 1);

   logic [CNT_W-1:0] count_ff [2];
   logic [CNT_W-1:0] count_in [2];
   logic [SUM_W-1:0] sum_ff [2];
   logic [SUM_W-1:0] sum_in [2];
   logic             accept;
   logic [SUM_W-1:0] next_sum;
   logic [CNT_W-1:0] next_count;

   assign req_if.ready = !full;
   assign accept = req_if.valid && !full && ({1'b0, req_if.channel} < 2'(CHANNELS));
   assign next_sum = sum_ff[req_if.channel] + SUM_W'(req_if.sample);
   assign next_count = count_ff[req_if.channel] + 1'b1;

   always_comb begin
      count_in = count_ff;
      sum_in = sum_ff;
      push = 1'b0;
      push_entry.channel = req_if.channel;
      push_entry.sum = next_sum;
      if (accept) begin
         if (count_ff[req_if.channel] == '0) begin
            // The first sample of a reading is thrown away.
            count_in[req_if.channel] = CNT_W'(1);
            sum_in[req_if.channel] = '0;
         end else if (next_count == LastCount) begin
            push = 1'b1;
            count_in[req_if.channel] = '0;
            sum_in[req_if.channel] = '0;
         end else begin
            count_in[req_if.channel] = next_count;
            sum_in[req_if.channel] = next_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            count_ff[i] <= '0;
            sum_ff[i] <= '0;
         end
      end else begin
         count_ff <= count_in;
         sum_ff <= sum_in;
      end
   end

endmodule

// ----- sv/ntc_queue.sv -----
// ----------------------------------------------------------------------
// NTC reading queue
// Short queue of completed readings between front end and back end.
// ----------------------------------------------------------------------
module ntc_queue #(
   parameter int DEPTH = ntc_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ntc_pkg::ntc_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output ntc_pkg::ntc_entry_type head
);
   import ntc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);

   ntc_entry_type      store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_QW-1:0]  fill_ff, fill_in;

   assign full = (fill_ff == CNT_QW'(DEPTH));
   assign empty = (fill_ff == '0);
   assign head = store_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      fill_in = fill_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         fill_ff <= fill_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) full |-> !push || pop)
      else $error("reading pushed into a full queue");
   assert property (@(posedge clock) disable iff (reset) empty |-> !pop)
      else $error("reading popped from an empty queue");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("queue fill level lost a reading");

endmodule

// ----- sv/ntc_div.sv -----
// ----------------------------------------------------------------------
// NTC divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------
module ntc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ntc_pkg::div_req_type req,
   output ntc_pkg::div_rsp_type rsp
);
   import ntc_pkg::*;

   localparam int STEP_W = $clog2(DIV_W);

   logic [DIV_W:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DIV_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [DIV_W:0]    trial;
   logic [DIV_W+1:0]  diff;

   assign trial = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]};
   assign diff = {1'b0, trial} - {2'b0, den_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in = '0;
         quo_in = req.dividend;
         den_in = req.divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = diff[DIV_W+1] ? trial : diff[DIV_W:0];
         quo_in = {quo_ff[DIV_W-2:0], !diff[DIV_W+1]};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ----- sv/ntc_back.sv -----
// ----------------------------------------------------------------------
// NTC back end
// Registers, resistance, logarithms and Beta equation for one reading.
// ----------------------------------------------------------------------
module ntc_back #(
   parameter int OVERSAMPLE_COUNT = ntc_pkg::DEF_OVERSAMPLE
) (
   input  logic                   clock,
   input  logic                   reset,
   ntc_csr_if.sink                csr_if,
   ntc_rsp_if.source              rsp_if,
   input  logic                   empty,
   input  ntc_pkg::ntc_entry_type head,
   output logic                   pop,
   output ntc_pkg::div_req_type   div_req,
   input  ntc_pkg::div_rsp_type   div_rsp
);
   import ntc_pkg::*;

   localparam logic [SUM_W-1:0] FullScale = SUM_W'(OVERSAMPLE_COUNT * 1023);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RDIV = 4'd1;
   localparam logic [3:0] S_NORM = 4'd2;
   localparam logic [3:0] S_SQ   = 4'd3;
   localparam logic [3:0] S_LN1  = 4'd4;
   localparam logic [3:0] S_LN2  = 4'd5;
   localparam logic [3:0] S_YDIV = 4'd6;
   localparam logic [3:0] S_QDIV = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   logic [PULLUP_W-1:0] pullup_ff [2];
   logic [NOM_W-1:0]    nominal_ff [2];
   logic [BETA_W-1:0]   beta_ff [2];

   logic [3:0]               state_ff, state_in;
   logic                     ch_ff, ch_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [RES_W-1:0]         r_ff, r_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic [STAT_W-1:0]        st_ff, st_in;
   logic [NOM_W-1:0]         nom_ff, nom_in;
   logic [BETA_W-1:0]        bsel_ff, bsel_in;
   logic [31:0]              lm_ff, lm_in;
   logic [4:0]               le_ff, le_in;
   logic [31:0]              frac_ff, frac_in;
   logic [4:0]               lcnt_ff, lcnt_in;
   logic                     which_ff, which_in;
   logic [36:0]              a_ff, a_in, b_ff, b_in;
   logic                     neg_ff, neg_in;
   logic [4:0]               maghi_ff, maghi_in;
   logic [63:0]              prod_ff, prod_in;
   div_req_type              div_req_ff, div_req_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     o_ch_ff, o_ch_in;
   logic [SUM_W-1:0]         o_sum_ff, o_sum_in;
   logic [RES_W-1:0]         o_r_ff, o_r_in;
   logic signed [TEMP_W-1:0] o_temp_ff, o_temp_in;
   logic [STAT_W-1:0]        o_st_ff, o_st_in;

   logic [63:0]        sq;
   logic [31:0]        frac_next;
   logic [36:0]        mag;
   logic [37:0]        ln;
   logic [63:0]        inv;
   logic signed [41:0] t16;
   logic [41:0]        tmag;
   logic [38:0]        rnd;
   logic [NOM_W-1:0]   head_nom;
   logic [BETA_W-1:0]  head_beta;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pullup_ff[0] <= PULLUP_W'(4700);
         pullup_ff[1] <= PULLUP_W'(4700);
         nominal_ff[0] <= NOM_W'(100000);
         nominal_ff[1] <= NOM_W'(100000);
         beta_ff[0] <= BETA_W'(4267);
         beta_ff[1] <= BETA_W'(3974);
      end else if (csr_if.valid) begin
         case (csr_if.index)
            REG_PULLUP_CH0: pullup_ff[0] <= csr_if.data[PULLUP_W-1:0];
            REG_PULLUP_CH1: pullup_ff[1] <= csr_if.data[PULLUP_W-1:0];
            REG_NOMINAL_CH0: nominal_ff[0] <= csr_if.data[NOM_W-1:0];
            REG_NOMINAL_CH1: nominal_ff[1] <= csr_if.data[NOM_W-1:0];
            REG_BETA_CH0: beta_ff[0] <= csr_if.data[BETA_W-1:0];
            REG_BETA_CH1: beta_ff[1] <= csr_if.data[BETA_W-1:0];
            default: ;
         endcase
      end
   end

   assign sq = 64'(lm_ff) * 64'(lm_ff);
   assign frac_next = {frac_ff[30:0], sq[63]};
   assign mag = (a_ff < b_ff) ? b_ff - a_ff : a_ff - b_ff;
   assign ln = 38'(maghi_ff) * 38'(LN2_Q32) + 38'(prod_ff[63:32]);
   assign inv = neg_ff ? INV0 - div_rsp.quotient : INV0 + div_rsp.quotient;
   assign t16 = $signed({2'b00, div_rsp.quotient[39:0]}) - ZERO_C_16;
   assign tmag = t16[41] ? 42'(-t16) : 42'(t16);
   assign rnd = 39'((tmag + 42'd8) >> 4);
   assign head_nom = (nominal_ff[head.channel] == '0) ? NOM_W'(1) : nominal_ff[head.channel];
   assign head_beta = (beta_ff[head.channel] == '0) ? BETA_W'(1) : beta_ff[head.channel];

   always_comb begin
      state_in = state_ff;
      ch_in = ch_ff;
      sum_in = sum_ff;
      r_in = r_ff;
      temp_in = temp_ff;
      st_in = st_ff;
      nom_in = nom_ff;
      bsel_in = bsel_ff;
      lm_in = lm_ff;
      le_in = le_ff;
      frac_in = frac_ff;
      lcnt_in = lcnt_ff;
      which_in = which_ff;
      a_in = a_ff;
      b_in = b_ff;
      neg_in = neg_ff;
      maghi_in = maghi_ff;
      prod_in = prod_ff;
      div_req_in = div_req_ff;
      div_req_in.start = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      o_ch_in = o_ch_ff;
      o_sum_in = o_sum_ff;
      o_r_in = o_r_ff;
      o_temp_in = o_temp_ff;
      o_st_in = o_st_ff;
      pop = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               ch_in = head.channel;
               sum_in = head.sum;
               nom_in = head_nom;
               bsel_in = head_beta;
               if (head.sum == '0) begin
                  r_in = '0;
                  temp_in = LIMIT_MC;
                  st_in = ST_SHORT;
                  state_in = S_OUT;
               end else if (head.sum >= FullScale) begin
                  r_in = '1;
                  temp_in = -LIMIT_MC;
                  st_in = ST_OPEN;
                  state_in = S_OUT;
               end else begin
                  div_req_in.start = 1'b1;
                  div_req_in.dividend =
                     64'(32'(pullup_ff[head.channel]) * 32'(head.sum));
                  div_req_in.divisor = 64'(FullScale - head.sum);
                  state_in = S_RDIV;
               end
            end
         end
         S_RDIV: begin
            if (div_rsp.done) begin
               r_in = div_rsp.quotient[RES_W-1:0];
               if (div_rsp.quotient[RES_W-1:0] == '0) begin
                  temp_in = LIMIT_MC;
                  st_in = ST_SHORT;
                  state_in = S_OUT;
               end else begin
                  lm_in = div_rsp.quotient[31:0];
                  le_in = 5'd31;
                  which_in = 1'b0;
                  state_in = S_NORM;
               end
            end
         end
         S_NORM: begin
            // Shift the top set bit up to bit 31, tracking its index.
            if (lm_ff[31]) begin
               lcnt_in = '0;
               frac_in = '0;
               state_in = S_SQ;
            end else begin
               lm_in = {lm_ff[30:0], 1'b0};
               le_in = le_ff - 1'b1;
            end
         end
         S_SQ: begin
            frac_in = frac_next;
            lm_in = sq[63] ? sq[63:32] : sq[62:31];
            lcnt_in = lcnt_ff + 1'b1;
            if (lcnt_ff == 5'd31) begin
               if (!which_ff) begin
                  a_in = {le_ff, frac_next};
                  lm_in = 32'(nom_ff);
                  le_in = 5'd31;
                  which_in = 1'b1;
                  state_in = S_NORM;
               end else begin
                  b_in = {le_ff, frac_next};
                  state_in = S_LN1;
               end
            end
         end
         S_LN1: begin
            neg_in = a_ff < b_ff;
            maghi_in = mag[36:32];
            prod_in = 64'(mag[31:0]) * 64'(LN2_Q32);
            state_in = S_LN2;
         end
         S_LN2: begin
            div_req_in.start = 1'b1;
            div_req_in.dividend = 64'({ln, 16'b0});
            div_req_in.divisor = 64'(bsel_ff);
            state_in = S_YDIV;
         end
         S_YDIV: begin
            if (div_rsp.done) begin
               if (neg_ff && div_rsp.quotient >= INV0) begin
                  temp_in = LIMIT_MC;
                  st_in = ST_SAT;
                  state_in = S_OUT;
               end else begin
                  div_req_in.start = 1'b1;
                  div_req_in.dividend = Q_NUM;
                  div_req_in.divisor = inv;
                  state_in = S_QDIV;
               end
            end
         end
         S_QDIV: begin
            if (div_rsp.done) begin
               state_in = S_OUT;
               if (div_rsp.quotient[63:40] != '0 || rnd > 39'(LIMIT_MC)) begin
                  temp_in = (div_rsp.quotient[63:40] != '0 || !t16[41]) ?
                            LIMIT_MC : -LIMIT_MC;
                  st_in = ST_SAT;
               end else begin
                  temp_in = t16[41] ? -$signed(TEMP_W'(rnd)) : $signed(TEMP_W'(rnd));
                  st_in = ST_NORMAL;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               o_ch_in = ch_ff;
               o_sum_in = sum_ff;
               o_r_in = r_ff;
               o_temp_in = temp_ff;
               o_st_in = st_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ch_ff <= ch_in;
      sum_ff <= sum_in;
      r_ff <= r_in;
      temp_ff <= temp_in;
      st_ff <= st_in;
      nom_ff <= nom_in;
      bsel_ff <= bsel_in;
      lm_ff <= lm_in;
      le_ff <= le_in;
      frac_ff <= frac_in;
      lcnt_ff <= lcnt_in;
      which_ff <= which_in;
      a_ff <= a_in;
      b_ff <= b_in;
      neg_ff <= neg_in;
      maghi_ff <= maghi_in;
      prod_ff <= prod_in;
      o_ch_ff <= o_ch_in;
      o_sum_ff <= o_sum_in;
      o_r_ff <= o_r_in;
      o_temp_ff <= o_temp_in;
      o_st_ff <= o_st_in;
      div_req_ff.dividend <= div_req_in.dividend;
      div_req_ff.divisor <= div_req_in.divisor;
      if (reset) begin
         state_ff <= S_IDLE;
         div_req_ff.start <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         div_req_ff.start <= div_req_in.start;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign div_req = div_req_ff;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.out_channel = o_ch_ff;
   assign rsp_if.raw_sum = o_sum_ff;
   assign rsp_if.resistance_ohms = o_r_ff;
   assign rsp_if.temp_mdeg = o_temp_ff;
   assign rsp_if.status = o_st_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && o_st_ff == ST_SHORT |-> o_r_ff == '0 && o_temp_ff == LIMIT_MC)
      else $error("short result with wrong resistance or temperature");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && o_st_ff == ST_OPEN |-> o_r_ff == '1 && o_temp_ff == -LIMIT_MC)
      else $error("open result with wrong resistance or temperature");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && o_st_ff == ST_NORMAL |-> o_temp_ff <= LIMIT_MC && o_temp_ff >= -LIMIT_MC)
      else $error("normal result outside the temperature range");
   assert property (@(posedge clock) disable iff (reset) div_req_ff.start |=> div_rsp.busy)
      else $error("divider did not take its operands");
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.busy |-> state_ff == S_RDIV || state_ff == S_YDIV || state_ff == S_QDIV)
      else $error("divider running outside a division step");

endmodule

// ----- sim/tb_ntc_thermistor_converter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------
// NTC thermistor converter testbench
// Streams oversampled readings on both channels through the converter and
// checks every result against a bit-accurate Beta-equation predictor, over
// several register settings and several idling patterns on both channels.
// ----------------------------------------------------------------------
module tb_ntc_thermistor_converter;
   import ntc_pkg::*;

   localparam int  READING_LEN = DEF_OVERSAMPLE + 1;
   localparam int  FULL_SCALE  = DEF_OVERSAMPLE * 1023;
   localparam int  SETTLE      = 400;
   localparam int  CYCLE_LIMIT = 500000;
   localparam int  LIMIT_TEMP  = 999000;

   typedef struct {
      logic                     channel;
      logic [SAMPLE_W-1:0]      sample;
   } sample_item_type;

   typedef struct {
      logic                     channel;
      logic [SUM_W-1:0]         sum;
      logic [RES_W-1:0]         res;
      logic [TEMP_W-1:0]        temp;
      logic [STAT_W-1:0]        status;
   } reading_type;

   logic clock;
   logic reset;

   ntc_req_if req_if ();
   ntc_rsp_if rsp_if ();
   ntc_csr_if csr_if ();

   ntc_thermistor_converter dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   sample_item_type pending_samples[$];
   reading_type     expected_readings[$];

   // Predictor copy of the registers and the per-channel accumulators.
   logic [PULLUP_W-1:0] pullup_ohms[2];
   logic [NOM_W-1:0]    nominal_ohms[2];
   logic [BETA_W-1:0]   beta_kelvin[2];
   logic [SUM_W-1:0]    acc_sum[2];
   logic [CNT_W-1:0]    acc_count[2];

   int  errors;
   int  cycles;
   int  src_idle_pct;
   int  snk_stall_pct;
   logic req_taken;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] log2_fixed(input logic [31:0] value);
      logic [31:0] x;
      logic [63:0] mant;
      logic [63:0] sq;
      logic [31:0] frac;
      int          top;
      x = (value == 0) ? 32'd1 : value;
      top = 31;
      while (x[top] == 1'b0)
         top--;
      mant = 64'(x) << (31 - top);
      frac = '0;
      for (int i = 0; i < 32; i++) begin
         sq = mant * mant;
         frac = {frac[30:0], sq[63]};
         mant = sq[63] ? (sq >> 32) : (sq >> 31);
      end
      return {32'(top), frac};
   endfunction

   function automatic void beta_temperature(input logic [31:0] r, input logic [31:0] r0_in,
                                            input logic [31:0] beta_in,
                                            output int temp, output logic [STAT_W-1:0] st);
      logic [63:0] r0, beta, a, b, mag, ln, y, inv, q, inv0;
      logic        below;
      longint      t16, tc;
      inv0 = (64'd20 << 48) / 64'd5963;
      r0 = (r0_in == 0) ? 64'd1 : 64'(r0_in);
      beta = (beta_in == 0) ? 64'd1 : 64'(beta_in);
      a = log2_fixed(r);
      b = log2_fixed(r0[31:0]);
      below = a < b;
      mag = below ? b - a : a - b;
      ln = (mag >> 32) * 64'(LN2_Q32) + (({32'd0, mag[31:0]} * 64'(LN2_Q32)) >> 32);
      y = (ln << 16) / beta;
      if (below) begin
         if (y >= inv0) begin
            temp = LIMIT_TEMP;
            st = ST_SAT;
            return;
         end
         inv = inv0 - y;
      end else begin
         inv = inv0 + y;
      end
      q = (64'd16000 << 48) / inv;
      if (q >= (64'd1 << 40)) begin
         temp = LIMIT_TEMP;
         st = ST_SAT;
         return;
      end
      t16 = longint'(q) - 64'sd4370400;
      if (t16 >= 0)
         tc = (t16 + 8) / 16;
      else
         tc = -((-t16 + 8) / 16);
      st = ST_NORMAL;
      if (tc > LIMIT_TEMP) begin
         tc = LIMIT_TEMP;
         st = ST_SAT;
      end else if (tc < -LIMIT_TEMP) begin
         tc = -LIMIT_TEMP;
         st = ST_SAT;
      end
      temp = int'(tc);
   endfunction

   function automatic reading_type convert_reading(input logic ch, input logic [SUM_W-1:0] sum);
      reading_type rd;
      int          temp;
      rd.channel = ch;
      rd.sum = sum;
      if (sum == 0)
         rd.res = '0;
      else if (sum >= FULL_SCALE)
         rd.res = '1;
      else
         rd.res = 32'((64'(pullup_ohms[ch]) * 64'(sum)) / 64'(FULL_SCALE - sum));
      if (rd.res == 0) begin
         temp = LIMIT_TEMP;
         rd.status = ST_SHORT;
      end else if (rd.res == '1) begin
         temp = -LIMIT_TEMP;
         rd.status = ST_OPEN;
      end else begin
         beta_temperature(rd.res, 32'(nominal_ohms[ch]), 32'(beta_kelvin[ch]), temp,
                          rd.status);
      end
      rd.temp = temp[TEMP_W-1:0];
      return rd;
   endfunction

   // Register writes and sample transactions update the predictor as they are accepted; results are checked as taken.
   always @(posedge clock) begin
      reading_type rd;
      logic        ch;
      req_taken <= req_if.valid && req_if.ready;
      if (reset) begin
         pullup_ohms <= '{16'd4700, 16'd4700};
         nominal_ohms <= '{24'd100000, 24'd100000};
         beta_kelvin <= '{16'd4267, 16'd3974};
         acc_sum <= '{default: '0};
         acc_count <= '{default: '0};
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               REG_PULLUP_CH0:  pullup_ohms[0] <= csr_if.data[PULLUP_W-1:0];
               REG_PULLUP_CH1:  pullup_ohms[1] <= csr_if.data[PULLUP_W-1:0];
               REG_NOMINAL_CH0: nominal_ohms[0] <= csr_if.data[NOM_W-1:0];
               REG_NOMINAL_CH1: nominal_ohms[1] <= csr_if.data[NOM_W-1:0];
               REG_BETA_CH0:    beta_kelvin[0] <= csr_if.data[BETA_W-1:0];
               REG_BETA_CH1:    beta_kelvin[1] <= csr_if.data[BETA_W-1:0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            ch = req_if.channel;
            if (acc_count[ch] == 0) begin
               acc_count[ch] <= CNT_W'(1);
               acc_sum[ch] <= '0;
            end else if (acc_count[ch] == CNT_W'(DEF_OVERSAMPLE)) begin
               expected_readings.push_back(
                  convert_reading(ch, acc_sum[ch] + SUM_W'(req_if.sample)));
               acc_count[ch] <= '0;
               acc_sum[ch] <= '0;
            end else begin
               acc_count[ch] <= acc_count[ch] + 1'b1;
               acc_sum[ch] <= acc_sum[ch] + SUM_W'(req_if.sample);
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_readings.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual ch=%0d sum=%0d", $time,
                        rsp_if.out_channel, rsp_if.raw_sum);
            end else begin
               rd = expected_readings.pop_front();
               if (rsp_if.out_channel !== rd.channel || rsp_if.raw_sum !== rd.sum ||
                   rsp_if.resistance_ohms !== rd.res || rsp_if.temp_mdeg !== rd.temp ||
                   rsp_if.status !== rd.status) begin
                  errors++;
                  $display("%0t: mismatch, expected ch=%0d sum=%0d res=%0d temp=%0d st=%0d",
                           $time, rd.channel, rd.sum, rd.res, $signed(rd.temp), rd.status);
                  $display("%0t:           actual   ch=%0d sum=%0d res=%0d temp=%0d st=%0d",
                           $time, rsp_if.out_channel, rsp_if.raw_sum, rsp_if.resistance_ohms,
                           rsp_if.temp_mdeg, rsp_if.status);
               end
            end
         end
      end
   end

   // Sample driver: a transaction stays on the bus until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (pending_samples.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
            sample_item_type it;
            it = pending_samples.pop_front();
            req_if.valid <= 1'b1;
            req_if.channel <= it.channel;
            req_if.sample <= it.sample;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
      rsp_if.ready <= !reset && ($urandom_range(99) >= snk_stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic write_register(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Two readings, one per channel, interleaved at random. A level of -1 means
   // fully random samples; 0 and 1023 are exact, otherwise samples jitter around the level.
   task automatic queue_readings(input int level0, input int level1);
      int   left[2];
      int   lvl[2];
      int   v;
      logic ch;
      left = '{READING_LEN, READING_LEN};
      lvl = '{level0, level1};
      while (left[0] + left[1] > 0) begin
         ch = (left[0] == 0) ? 1'b1 : (left[1] == 0) ? 1'b0 : 1'($urandom_range(1));
         if (lvl[ch] < 0)
            v = $urandom_range(1023);
         else if (lvl[ch] == 0 || lvl[ch] == 1023)
            v = lvl[ch];
         else
            v = lvl[ch] + $urandom_range(16) - 8;
         v = (v < 0) ? 0 : (v > 1023) ? 1023 : v;
         pending_samples.push_back('{ch, SAMPLE_W'(v)});
         left[ch]--;
      end
   endtask

   task automatic queue_directed();
      queue_readings(0, 1023);
      queue_readings(1023, 0);
      // Sum of one on channel zero, one below full scale on channel one.
      pending_samples.push_back('{1'b0, 10'd0});
      pending_samples.push_back('{1'b0, 10'd1});
      repeat (DEF_OVERSAMPLE - 1) pending_samples.push_back('{1'b0, 10'd0});
      pending_samples.push_back('{1'b1, 10'd0});
      pending_samples.push_back('{1'b1, 10'd1022});
      repeat (DEF_OVERSAMPLE - 1) pending_samples.push_back('{1'b1, 10'd1023});
   endtask

   task automatic queue_random(input int count);
      int target;
      target = pending_samples.size() + count;
      while (pending_samples.size() < target) begin
         case ($urandom_range(9))
            0: queue_readings(-1, -1);
            1: queue_readings($urandom_range(3), 1023 - $urandom_range(3));
            2: begin
               // A stray sample knocks a channel out of step with its readings.
               pending_samples.push_back('{1'($urandom_range(1)), 10'($urandom_range(1023))});
            end
            default: queue_readings($urandom_range(1023), $urandom_range(1023));
         endcase
      end
   endtask

   // Nothing is left in flight once every sample is taken and every result checked.
   task automatic wait_idle();
      wait (pending_samples.size() == 0 && !req_if.valid && expected_readings.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      src_idle_pct = 0;
      snk_stall_pct = 0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.channel = 1'b0;
      req_if.sample = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = REG_PULLUP_CH0;
      csr_if.data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1: begin
               src_idle_pct = 51;
               snk_stall_pct = 0;
               write_register(REG_PULLUP_CH0, 24'd1);
               write_register(REG_PULLUP_CH1, 24'hFFFFFF);
               write_register(REG_NOMINAL_CH0, 24'd1);
               write_register(REG_NOMINAL_CH1, 24'd10000000);
               write_register(REG_BETA_CH0, 24'd1000);
               write_register(REG_BETA_CH1, 24'd65535);
            end
            2: begin
               src_idle_pct = 0;
               snk_stall_pct = 51;
               write_register(REG_PULLUP_CH0, 24'hFFFF);
               write_register(REG_PULLUP_CH1, 24'($urandom_range(65535, 1)));
               write_register(REG_NOMINAL_CH0, 24'd10000000);
               write_register(REG_NOMINAL_CH1, 24'($urandom_range(10000000, 1)));
               write_register(REG_BETA_CH0, 24'd65535);
               write_register(REG_BETA_CH1, 24'($urandom_range(65535, 1000)));
            end
            3: begin
               src_idle_pct = 11;
               snk_stall_pct = 11;
               write_register(REG_PULLUP_CH0, 24'($urandom_range(65535, 1)));
               write_register(REG_PULLUP_CH1, 24'd1);
               write_register(REG_NOMINAL_CH0, 24'($urandom_range(200000, 1000)));
               // Zero nominal and Beta values are taken as one.
               write_register(REG_NOMINAL_CH1, 24'd0);
               write_register(REG_BETA_CH0, 24'($urandom_range(5000, 3000)));
               write_register(REG_BETA_CH1, 24'd0);
            end
            default: ;
         endcase
         queue_directed();
         queue_random(160);
         wait_idle();
      end

      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
